>>> design/mft_pkg.sv
package mft_pkg;

  // Defaults for the top-level parameters
  localparam int MOTOR_SLOTS_DEF = 8;
  localparam int GROUP_SLOTS_DEF = 8;

  // Field widths
  localparam int REQ_W     = 3;
  localparam int IDX_W     = 3;
  localparam int ANGLE_W   = 13;
  localparam int WORD_W    = 16;
  localparam int TEMP_W    = 8;
  localparam int TIME_W    = 32;
  localparam int TOTAL_W   = 32;
  localparam int MAP_W     = 8;
  localparam int MISS_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int GMAP_W    = 24;
  localparam int GIDX_W    = 3;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 136;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Angle unwrap thresholds
  localparam int ANGLE_LOW  = 2048;
  localparam int ANGLE_HIGH = 6144;
  localparam int ANGLE_SPAN = 8192;
  localparam int MISS_MAX   = 7;

  // Configuration reset values
  localparam logic [TIME_W-1:0] TIMEOUT_RST    = 32'd100000;
  localparam logic [MISS_W-1:0] MISS_LIMIT_RST = 3'd3;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_FRAME   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CHECK   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ENABLE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ZERO    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FRAME  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CHECK  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CMD    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSLIM = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // latch the input word, clear the drop accumulator
    logic commit;     // apply a frame or command and load its result
    logic walk_step;  // run the timeout test on the walk slot
    logic load_chk;   // load the result of a finished check
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic new_chk;    // word on the input bus is a timeout check
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

endpackage

>>> design/mft_ctrl.sv
module mft_ctrl #(
  parameter int MOTOR_SLOTS = mft_pkg::MOTOR_SLOTS_DEF,
  parameter int SLOT_W      = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mft_pkg::dp_stat_t stat,
  output mft_pkg::ctl_cmd_t cmd,
  output logic [SLOT_W-1:0] walk_slot
);
  import mft_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_CDONE = 2'd3;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MOTOR_SLOTS - 1);

  logic [1:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign walk_slot = cnt_r;

  // Sequence one word: execute, or walk the slots and report
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.load_in   = accept;
    cmd.commit    = 1'b0;
    cmd.walk_step = 1'b0;
    cmd.load_chk  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          state_nxt = stat.new_chk ? S_WALK : S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (cnt_r == LAST_SLOT) begin
          state_nxt = S_CDONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_CDONE: begin
        if (stat.out_free) begin
          cmd.load_chk = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> design/mft_dp.sv
module mft_dp #(
  parameter int MOTOR_SLOTS = mft_pkg::MOTOR_SLOTS_DEF,
  parameter int GROUP_SLOTS = mft_pkg::GROUP_SLOTS_DEF,
  parameter int SLOT_W      = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mft_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [mft_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [mft_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [mft_pkg::REQ_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mft_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [mft_pkg::STATUS_W-1:0]      out_tuser,
  input  mft_pkg::ctl_cmd_t                 cmd,
  input  logic [SLOT_W-1:0]                 walk_slot,
  output mft_pkg::dp_stat_t                 stat
);
  import mft_pkg::*;

  localparam logic [MOTOR_SLOTS-1:0] ONE_SLOT = MOTOR_SLOTS'(1);

  // Configuration registers
  logic [MAP_W-1:0]  present_r;
  logic [GMAP_W-1:0] group_map_r;
  logic [TIME_W-1:0] timeout_r;
  logic [MISS_W-1:0] miss_limit_r;

  // Latched input word
  logic [REQ_W-1:0]   req_r;
  logic [IDX_W-1:0]   idx_r;
  logic [ANGLE_W-1:0] angle_r;
  logic [WORD_W-1:0]  speed_r;
  logic [WORD_W-1:0]  current_r;
  logic [TEMP_W-1:0]  temp_r;
  logic [TIME_W-1:0]  now_r;

  // Per-slot state
  logic [ANGLE_W-1:0] prev_angle_r [MOTOR_SLOTS];
  logic [TOTAL_W-1:0] turn_r       [MOTOR_SLOTS];
  logic [TIME_W-1:0]  last_time_r  [MOTOR_SLOTS];
  logic [MISS_W-1:0]  miss_r       [MOTOR_SLOTS];
  logic [MOTOR_SLOTS-1:0] online_r, dropped_r, arrived_r, drop_acc_r;

  // Output register
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   o_status_r;
  logic [IDX_W-1:0]      o_motor_r;
  logic [TOTAL_W-1:0]    o_total_r;
  logic [WORD_W-1:0]     o_speed_r;
  logic [WORD_W-1:0]     o_current_r;
  logic [TEMP_W-1:0]     o_temp_r;
  logic [TIME_W-1:0]     o_elapsed_r;
  logic [MAP_W-1:0]      o_full_r;
  logic                  o_rec_r;
  logic [MAP_W-1:0]      o_offline_r;
  logic [MAP_W-1:0]      o_online_r;

  // Execute-cycle signals
  logic [MOTOR_SLOTS-1:0] present_vec, slot_bit;
  logic [SLOT_W-1:0]      sel;
  logic                   idx_ok, hit, is_frame;
  logic [ANGLE_W-1:0]     cur_prev;
  logic [TOTAL_W-1:0]     cur_turn;
  logic [TIME_W-1:0]      cur_last;
  logic [MISS_W-1:0]      cur_miss;
  logic signed [14:0]     delta;
  logic [TOTAL_W-1:0]     turn_new;
  logic [TIME_W-1:0]      elapsed;
  logic                   rec;
  logic [MISS_W-1:0]      miss_frame;
  logic [MOTOR_SLOTS-1:0] ex_online, ex_dropped, ex_arrived, arr_set, clr_mask, mem;
  logic [MAP_W-1:0]       full;
  logic [STATUS_W-1:0]    ex_status;

  // Walk-step signals
  logic                   w_due;
  logic [MISS_W-1:0]      w_miss;
  logic                   w_drop;

  assign present_vec  = present_r[MOTOR_SLOTS-1:0];
  assign stat.new_chk = (in_tuser == REQ_CHECK);
  assign stat.out_free = !out_valid_r || out_tready;

  assign sel      = idx_r[SLOT_W-1:0];
  assign idx_ok   = (int'(idx_r) < MOTOR_SLOTS);
  assign hit      = idx_ok && present_r[idx_r];
  assign slot_bit = idx_ok ? (ONE_SLOT << idx_r) : '0;
  assign is_frame = (req_r == REQ_FRAME) && hit;

  assign cur_prev = prev_angle_r[sel];
  assign cur_turn = turn_r[sel];
  assign cur_last = last_time_r[sel];
  assign cur_miss = miss_r[sel];

  // Unwrap the angle step across the encoder rollover
  always_comb begin
    delta = $signed({2'b00, angle_r}) - $signed({2'b00, cur_prev});
    if (angle_r < ANGLE_W'(ANGLE_LOW) && cur_prev > ANGLE_W'(ANGLE_HIGH)) begin
      delta = delta + 15'sd8192;
    end else if (angle_r > ANGLE_W'(ANGLE_HIGH) && cur_prev < ANGLE_W'(ANGLE_LOW)) begin
      delta = delta - 15'sd8192;
    end
  end

  assign turn_new = cur_turn + {{(TOTAL_W-15){delta[14]}}, delta};
  assign elapsed  = (cur_last == '0) ? TIME_W'(1) : (now_r - cur_last);

  // Recover a dropped motor, or bleed off one miss
  assign rec        = (cur_miss > miss_limit_r);
  assign miss_frame = rec ? '0 : ((cur_miss != '0) ? (cur_miss - 1'b1) : '0);

  // Next bitmaps and status for a frame or command
  always_comb begin
    ex_online  = online_r;
    ex_dropped = dropped_r;
    arr_set    = arrived_r;
    ex_status  = ST_CMD;
    if (req_r <= REQ_CLEAR && !hit) begin
      ex_status = ST_ABSENT;
    end else begin
      case (req_r)
        REQ_FRAME: begin
          ex_status = ST_FRAME;
          arr_set   = arrived_r | slot_bit;
          if (rec) begin
            ex_online  = online_r | slot_bit;
            ex_dropped = dropped_r & ~slot_bit;
          end
        end
        REQ_ENABLE:  ex_online = online_r | slot_bit;
        REQ_DISABLE: ex_online = online_r & ~slot_bit;
        REQ_CLEAR:   ex_online = online_r | slot_bit;
        default: ;
      endcase
    end
  end

  // Find groups whose active members have all arrived
  always_comb begin
    full     = '0;
    clr_mask = '0;
    for (int g = 0; g < GROUP_SLOTS; g++) begin
      for (int s = 0; s < MOTOR_SLOTS; s++) begin
        mem[s] = (group_map_r[GIDX_W*s +: GIDX_W] == GIDX_W'(g)) &&
                 present_vec[s] && !ex_dropped[s];
      end
      if (mem != '0 && (arr_set & mem) == mem) begin
        full[g]  = 1'b1;
        clr_mask = clr_mask | mem;
      end
    end
    ex_arrived = arr_set & ~clr_mask;
  end

  // Timeout test for the slot under the walk
  assign w_due  = present_vec[walk_slot] && online_r[walk_slot] &&
                  ((now_r - last_time_r[walk_slot]) > timeout_r);
  assign w_miss = (miss_r[walk_slot] < MISS_W'(MISS_MAX)) ?
                  (miss_r[walk_slot] + 1'b1) : miss_r[walk_slot];
  assign w_drop = w_due && (w_miss > miss_limit_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r    <= '0;
      group_map_r  <= '0;
      timeout_r    <= TIMEOUT_RST;
      miss_limit_r <= MISS_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PRESENT: present_r    <= cfg_wdata[MAP_W-1:0];
        CFG_GROUPS:  group_map_r  <= cfg_wdata[GMAP_W-1:0];
        CFG_TIMEOUT: timeout_r    <= cfg_wdata[TIME_W-1:0];
        CFG_MISSLIM: miss_limit_r <= cfg_wdata[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r     <= in_tuser;
      idx_r     <= in_tdata[2:0];
      angle_r   <= in_tdata[15:3];
      speed_r   <= in_tdata[31:16];
      current_r <= in_tdata[47:32];
      temp_r    <= in_tdata[55:48];
      now_r     <= in_tdata[87:56];
    end
  end

  // Slot state: commit a frame or command, or advance the walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MOTOR_SLOTS; s++) begin
        prev_angle_r[s] <= '0;
        turn_r[s]       <= '0;
        last_time_r[s]  <= '0;
        miss_r[s]       <= '0;
      end
      online_r   <= '1;
      dropped_r  <= '0;
      arrived_r  <= '0;
      drop_acc_r <= '0;
    end else begin
      if (cmd.load_in) begin
        drop_acc_r <= '0;
      end
      if (cmd.commit) begin
        online_r  <= ex_online;
        dropped_r <= ex_dropped;
        // Arrival bits move only on a taken frame
        if (is_frame) begin
          arrived_r <= ex_arrived;
        end
        if (hit) begin
          case (req_r)
            REQ_FRAME: begin
              prev_angle_r[sel] <= angle_r;
              turn_r[sel]       <= turn_new;
              last_time_r[sel]  <= now_r;
              miss_r[sel]       <= miss_frame;
            end
            REQ_ZERO:  turn_r[sel] <= '0;
            REQ_CLEAR: miss_r[sel] <= '0;
            default: ;
          endcase
        end
      end
      if (cmd.walk_step && w_due) begin
        miss_r[walk_slot] <= w_miss;
        if (w_drop) begin
          dropped_r[walk_slot]  <= 1'b1;
          online_r[walk_slot]   <= 1'b0;
          drop_acc_r[walk_slot] <= 1'b1;
        end
      end
    end
  end

  // Output valid: set on load, drop on handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit || cmd.load_chk) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_status_r  <= ex_status;
      o_motor_r   <= idx_r;
      o_total_r   <= is_frame ? turn_new : '0;
      o_speed_r   <= is_frame ? speed_r : '0;
      o_current_r <= is_frame ? current_r : '0;
      o_temp_r    <= is_frame ? temp_r : '0;
      o_elapsed_r <= is_frame ? elapsed : '0;
      o_full_r    <= is_frame ? full : '0;
      o_rec_r     <= is_frame && rec;
      o_offline_r <= '0;
      o_online_r  <= MAP_W'(ex_online & present_vec);
    end else if (cmd.load_chk) begin
      o_status_r  <= ST_CHECK;
      o_motor_r   <= idx_r;
      o_total_r   <= '0;
      o_speed_r   <= '0;
      o_current_r <= '0;
      o_temp_r    <= '0;
      o_elapsed_r <= '0;
      o_full_r    <= '0;
      o_rec_r     <= 1'b0;
      o_offline_r <= MAP_W'(drop_acc_r);
      o_online_r  <= MAP_W'(online_r & present_vec);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_status_r;
  assign out_tdata  = {4'b0000, o_online_r, o_offline_r, o_rec_r, o_full_r, o_elapsed_r,
                       o_temp_r, o_current_r, o_speed_r, o_total_r, o_motor_r};

endmodule

>>> design/motor_feedback_tracker.sv
// Channel | Handshake             | tuser             | tdata
// in_     | in_tvalid/in_tready   | req_type          | motor_index .. time_now
// out_    | out_tvalid/out_tready | status            | motor_out .. online_map
// cfg_    | cfg_we                | -                 | cfg_addr, cfg_wdata
//
// A frame or command is accepted, then one execute step updates the slot state
// and loads the output register once the output register is free.
// A timeout check walks every slot, one slot per cycle, then reports its result.
// rst_n is synchronous: slot state clears, all slots read online, config takes
// its defaults.
// A result waits in the output register; the next word is accepted meanwhile and
// waits in its last state until the output register is free.
module motor_feedback_tracker #(
  parameter int MOTOR_SLOTS = mft_pkg::MOTOR_SLOTS_DEF,
  parameter int GROUP_SLOTS = mft_pkg::GROUP_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mft_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [mft_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // motor_index[2:0], raw_angle[15:3], raw_speed[31:16], raw_current[47:32],
  // raw_temp[55:48], time_now[87:56]
  input  logic [mft_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[2:0]
  input  logic [mft_pkg::REQ_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // motor_out[2:0], angle_total[34:3], speed_out[50:35], current_out[66:51],
  // temp_out[74:67], elapsed[106:75], groups_full[114:107], recovered[115],
  // newly_offline[123:116], online_map[131:124], zero pad[135:132]
  output logic [mft_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [mft_pkg::STATUS_W-1:0]   out_tuser
);
  import mft_pkg::*;

  localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

  ctl_cmd_t          cmd;
  dp_stat_t          stat;
  logic [SLOT_W-1:0] walk_slot;

  mft_ctrl #(
    .MOTOR_SLOTS (MOTOR_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd),
    .walk_slot (walk_slot)
  );

  mft_dp #(
    .MOTOR_SLOTS (MOTOR_SLOTS),
    .GROUP_SLOTS (GROUP_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .walk_slot  (walk_slot),
    .stat       (stat)
  );

endmodule

>>> design/mft_checker.sv
module mft_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mft_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [mft_pkg::STATUS_W-1:0]   out_tuser
);
  import mft_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // One word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is in work");

  // Frame fields stay zero outside frame results
  a_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_FRAME |-> out_tdata[115:3] == '0)
    else $error("frame fields set in a non-frame result");

  // Drops are only reported by a check
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_CHECK |-> out_tdata[123:116] == '0)
    else $error("drop map set outside a check result");

endmodule

bind motor_feedback_tracker mft_checker u_mft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
